// ----- hw/rtl/vrts_pkg.sv -----
// types and helpers shared by the sponge voxel traversal pipeline
// no dependencies
package vrts_pkg;

   localparam int unsigned CoordW = 16;
   localparam int unsigned DistW  = 32;
   localparam int unsigned ClrW   = 6;
   localparam int unsigned StepW  = 8;
   localparam int unsigned ReqW   = 248;
   localparam int unsigned RspW   = 32;

   localparam logic [31:0]      SpongeMask = 32'hF99F9009;
   localparam logic [StepW-1:0] MissDist   = 8'd255;
   localparam logic [ClrW-1:0]  MissClr    = 6'd63;

   typedef struct packed {
      logic [CoordW-1:0]       vx;
      logic [CoordW-1:0]       vy;
      logic [CoordW-1:0]       vz;
      logic signed [DistW-1:0] tx;
      logic signed [DistW-1:0] ty;
      logic signed [DistW-1:0] tz;
      logic [DistW-1:0]        dx;
      logic [DistW-1:0]        dy;
      logic [DistW-1:0]        dz;
      logic                    neg_x;
      logic                    neg_y;
      logic                    neg_z;
      logic                    hit;
      logic [ClrW-1:0]         clr;
      logic [StepW-1:0]        depth;
   } ray_type;

   function automatic logic cell_solid(input logic [5:0] t);
      logic [4:0] sh;
      sh = t[5] ? t[4:0] : ~t[4:0];
      return SpongeMask[sh];
   endfunction

   function automatic logic voxel_solid(input logic [CoordW-1:0] x,
                                        input logic [CoordW-1:0] y,
                                        input logic [CoordW-1:0] z);
      logic s0;
      logic s1;
      logic s2;
      s0 = cell_solid({z[1:0], y[1:0], x[1:0]});
      s1 = cell_solid({z[3:2], y[3:2], x[3:2]});
      s2 = cell_solid({z[5:4], y[5:4], x[5:4]});
      return s0 & s1 & s2;
   endfunction

endpackage

// ----- hw/rtl/vrts_step.sv -----
// one traversal step: sponge test, first-hit capture, advance along smallest axis
// depends on vrts_pkg
module vrts_step #(
   parameter int unsigned STEP_IDX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  vrts_pkg::ray_type in_ray,
   output logic             out_valid,
   output vrts_pkg::ray_type out_ray
);
   import vrts_pkg::*;

   logic    valid_ff;
   ray_type ray_ff;
   ray_type ray_in;
   logic    solid;
   logic    take_x;
   logic    take_y;

   always_comb begin
      ray_in = in_ray;
      solid  = voxel_solid(in_ray.vx, in_ray.vy, in_ray.vz);
      if (!in_ray.hit && solid) begin
         ray_in.hit   = 1'b1;
         ray_in.clr   = in_ray.vx[ClrW-1:0] ^ in_ray.vy[ClrW-1:0] ^ in_ray.vz[ClrW-1:0];
         ray_in.depth = StepW'(STEP_IDX);
      end
      take_x = (in_ray.tx <= in_ray.ty) && (in_ray.tx <= in_ray.tz);
      take_y = (in_ray.ty < in_ray.tx) && (in_ray.ty < in_ray.tz);
      if (take_x) begin
         ray_in.vx = in_ray.neg_x ? in_ray.vx - 16'd1 : in_ray.vx + 16'd1;
         ray_in.tx = in_ray.tx + $signed(in_ray.dx);
      end else if (take_y) begin
         ray_in.vy = in_ray.neg_y ? in_ray.vy - 16'd1 : in_ray.vy + 16'd1;
         ray_in.ty = in_ray.ty + $signed(in_ray.dy);
      end else begin
         ray_in.vz = in_ray.neg_z ? in_ray.vz - 16'd1 : in_ray.vz + 16'd1;
         ray_in.tz = in_ray.tz + $signed(in_ray.dz);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ray_ff <= ray_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ray   = ray_ff;

endmodule

// ----- hw/rtl/vrts_shade.sv -----
// fog shading: light times color product, then shift and fog add into the output register
// depends on vrts_pkg
module vrts_shade (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  vrts_pkg::ray_type in_ray,
   output logic             out_valid,
   output logic [7:0]       red,
   output logic [7:0]       green,
   output logic [7:0]       blue,
   output logic             hit
);
   import vrts_pkg::*;

   logic             mul_valid_ff;
   logic [15:0]      shade_ff;
   logic [StepW-1:0] dist_ff;
   logic             hit_ff;
   logic [15:0]      shade_in;
   logic [StepW-1:0] light;

   logic             out_valid_ff;
   logic [7:0]       red_ff;
   logic [7:0]       blue_ff;
   logic             out_hit_ff;

   assign light    = MissDist - in_ray.depth;
   assign shade_in = 16'(light * in_ray.clr);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= in_valid;
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         shade_ff   <= shade_in;
         dist_ff    <= in_ray.depth;
         hit_ff     <= in_ray.hit;
         red_ff     <= shade_ff[14:7] + dist_ff;
         blue_ff    <= shade_ff[15:8] + dist_ff;
         out_hit_ff <= hit_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign red       = red_ff;
   assign green     = red_ff;
   assign blue      = blue_ff;
   assign hit       = out_hit_ff;

endmodule

// ----- hw/rtl/voxel_ray_traversal_sponge_unit.sv -----
// pipeline: one traversal step per stage, followed by the shade product and output registers
// throughput: one item per cycle; the whole pipeline advances together and stalls
// while a result waits at the output register
// reset: synchronous, active high, clears all stage valid bits; payload is not reset
// top level of the sponge voxel traversal pipeline
// depends on vrts_pkg, vrts_step, vrts_shade
module voxel_ray_traversal_sponge_unit #(
   parameter int unsigned STEPS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // voxel_x, voxel_y, voxel_z, tmax_x, tmax_y, tmax_z, delta_x, delta_y, delta_z,
   // neg_x, neg_y, neg_z, zero pad
   input  logic [vrts_pkg::ReqW-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // red, green, blue, hit, zero pad
   output logic [vrts_pkg::RspW-1:0] rsp_tdata
);
   import vrts_pkg::*;

   logic       en;
   logic       stage_valid [0:STEPS];
   ray_type    stage_ray   [0:STEPS];
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       hit;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_comb begin
      stage_valid[0]     = req_tvalid;
      stage_ray[0].vx    = req_tdata[15:0];
      stage_ray[0].vy    = req_tdata[31:16];
      stage_ray[0].vz    = req_tdata[47:32];
      stage_ray[0].tx    = $signed(req_tdata[79:48]);
      stage_ray[0].ty    = $signed(req_tdata[111:80]);
      stage_ray[0].tz    = $signed(req_tdata[143:112]);
      stage_ray[0].dx    = req_tdata[175:144];
      stage_ray[0].dy    = req_tdata[207:176];
      stage_ray[0].dz    = req_tdata[239:208];
      stage_ray[0].neg_x = req_tdata[240];
      stage_ray[0].neg_y = req_tdata[241];
      stage_ray[0].neg_z = req_tdata[242];
      stage_ray[0].hit   = 1'b0;
      stage_ray[0].clr   = MissClr;
      stage_ray[0].depth = MissDist;
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      vrts_step #(
         .STEP_IDX (k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (stage_valid[k]),
         .in_ray    (stage_ray[k]),
         .out_valid (stage_valid[k+1]),
         .out_ray   (stage_ray[k+1])
      );
   end

   vrts_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (stage_valid[STEPS]),
      .in_ray    (stage_ray[STEPS]),
      .out_valid (rsp_tvalid),
      .red       (red),
      .green     (green),
      .blue      (blue),
      .hit       (hit)
   );

   assign rsp_tdata = {7'd0, hit, blue, green, red};

   // a miss leaves a white pixel
   a_miss_white: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !hit |-> red == 8'd255 && green == 8'd255 && blue == 8'd255)
      else $error("miss result is not white");

   // a ray that has not hit keeps the miss distance
   a_miss_dist: assert property (@(posedge clock) disable iff (reset)
      stage_valid[STEPS] && !stage_ray[STEPS].hit |-> stage_ray[STEPS].depth == MissDist)
      else $error("unhit ray carries a distance");

   // a hit distance is a step number inside the pipeline
   a_hit_dist: assert property (@(posedge clock) disable iff (reset)
      stage_valid[STEPS] && stage_ray[STEPS].hit |-> 32'(stage_ray[STEPS].depth) < STEPS)
      else $error("hit distance out of range");

   // a stall freezes the last traversal stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(stage_valid[STEPS]))
      else $error("pipeline moved during stall");

endmodule

// ----- sim/voxel_ray_traversal_sponge_unit_test.sv -----
// self-checking bench for the sponge voxel traversal pipeline: rays in, shaded pixels out
// depends on vrts_pkg and voxel_ray_traversal_sponge_unit
`timescale 1ns / 100ps

module voxel_ray_traversal_sponge_unit_test;

   localparam int STEPS       = 64;
   localparam int LATENCY     = STEPS + 2;
   localparam int CYCLE_LIMIT = 300000;
   localparam int REPORT_CAP  = 30;

   typedef struct {
      logic [15:0]        vx;
      logic [15:0]        vy;
      logic [15:0]        vz;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
      logic [31:0]        dx;
      logic [31:0]        dy;
      logic [31:0]        dz;
      logic               nx;
      logic               ny;
      logic               nz;
   } ray_t;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       hit;
   } pixel_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // voxel_x, voxel_y, voxel_z, tmax_x, tmax_y, tmax_z, delta_x, delta_y, delta_z,
   // neg_x, neg_y, neg_z, zero pad
   logic [vrts_pkg::ReqW-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // red, green, blue, hit, zero pad
   logic [vrts_pkg::RspW-1:0] rsp_tdata;

   ray_t        rays_to_send[$];
   pixel_t      pixels_expected[$];
   ray_t        ray_on_bus;
   logic        req_taken = 1'b0;
   logic        rsp_blocked = 1'b0;
   int unsigned backlog_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned rays_sent = 0;
   int unsigned pixels_seen = 0;
   int unsigned hits_seen = 0;

   voxel_ray_traversal_sponge_unit #(
      .STEPS(STEPS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic triple_solid(input logic [5:0] t);
      logic [4:0] bit_sel;
      bit_sel = t[5] ? t[4:0] : 5'd31 - t[4:0];
      return vrts_pkg::SpongeMask[bit_sel];
   endfunction

   function automatic logic in_sponge(input logic [15:0] x, input logic [15:0] y,
                                      input logic [15:0] z);
      return triple_solid({z[1:0], y[1:0], x[1:0]}) &&
             triple_solid({z[3:2], y[3:2], x[3:2]}) &&
             triple_solid({z[5:4], y[5:4], x[5:4]});
   endfunction

   // walks the ray step by step and shades the first solid voxel with fog
   function automatic pixel_t trace_pixel(input ray_t r);
      logic [15:0]        px;
      logic [15:0]        py;
      logic [15:0]        pz;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic               found;
      logic [5:0]         color;
      logic [7:0]         depth;
      logic [7:0]         light;
      logic [15:0]        shade;
      pixel_t             p;
      px = r.vx;
      py = r.vy;
      pz = r.vz;
      cx = r.tx;
      cy = r.ty;
      cz = r.tz;
      found = 1'b0;
      color = 6'd63;
      depth = 8'd255;
      for (int k = 0; k < STEPS; k++) begin
         if (!found && in_sponge(px, py, pz)) begin
            found = 1'b1;
            color = px[5:0] ^ py[5:0] ^ pz[5:0];
            depth = k[7:0];
         end
         if (!(cx > cy) && !(cx > cz)) begin
            px = r.nx ? px - 16'd1 : px + 16'd1;
            cx = cx + r.dx;
         end else if (cy < cx && cy < cz) begin
            py = r.ny ? py - 16'd1 : py + 16'd1;
            cy = cy + r.dy;
         end else begin
            pz = r.nz ? pz - 16'd1 : pz + 16'd1;
            cz = cz + r.dz;
         end
      end
      light = 8'd255 - depth;
      shade = {8'd0, light} * {10'd0, color};
      p.red = shade[14:7] + depth;
      p.green = shade[14:7] + depth;
      p.blue = shade[15:8] + depth;
      p.hit = found;
      return p;
   endfunction

   function automatic logic [vrts_pkg::ReqW-1:0] pack_ray(input ray_t r);
      return {5'd0, r.nz, r.ny, r.nx, r.dz, r.dy, r.dx, r.tz, r.ty, r.tx, r.vz, r.vy, r.vx};
   endfunction

   function automatic ray_t make_ray(input logic [15:0] vx, input logic [15:0] vy,
                                     input logic [15:0] vz, input logic [31:0] tx,
                                     input logic [31:0] ty, input logic [31:0] tz,
                                     input logic [31:0] dx, input logic [31:0] dy,
                                     input logic [31:0] dz, input logic [2:0] neg);
      ray_t r;
      r.vx = vx;
      r.vy = vy;
      r.vz = vz;
      r.tx = tx;
      r.ty = ty;
      r.tz = tz;
      r.dx = dx;
      r.dy = dy;
      r.dz = dz;
      {r.nz, r.ny, r.nx} = neg;
      return r;
   endfunction

   function automatic ray_t random_ray();
      ray_t        r;
      int unsigned pick;
      int unsigned span;
      pick = $urandom_range(0, 99);
      r = make_ray(16'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, 3'($urandom));
      if (pick >= 20 && pick < 85) begin
         // well-formed ray: positive deltas, crossing distances within one delta
         span = 32'd1 << $urandom_range(4, 24);
         r.dx = $urandom_range(1, span);
         r.dy = $urandom_range(1, span);
         r.dz = $urandom_range(1, span);
         r.tx = $urandom_range(0, r.dx);
         r.ty = $urandom_range(0, r.dy);
         r.tz = $urandom_range(0, r.dz);
         if (pick < 40) begin
            r.vx = 16'($urandom_range(0, 127)) - 16'd64;
            r.vy = 16'($urandom_range(0, 127)) - 16'd64;
            r.vz = 16'($urandom_range(0, 127)) - 16'd64;
         end
      end else if (pick >= 85) begin
         // mostly along x through an empty row, late turns may still hit
         r.vy[1:0] = 2'b01;
         r.vz[1:0] = 2'b01;
         r.dx = $urandom_range(0, 1000);
         r.tx = $urandom_range(0, 1000);
         r.ty = $urandom_range(20000, 70000);
         r.tz = $urandom_range(20000, 70000);
         r.dy = $urandom_range(1, 50000);
         r.dz = $urandom_range(1, 50000);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      if (error_count < REPORT_CAP)
         $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want,
                  got);
      error_count++;
   endtask

   // driver: offers the next ray at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (rays_to_send.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
         end else begin
            ray_on_bus = rays_to_send.pop_front();
            req_tdata <= pack_ray(ray_on_bus);
            req_tvalid <= 1'b1;
         end
      end
   end

   // receiver ready, with random stalls and the long hold-off
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !rsp_blocked && $urandom_range(0, 99) >= rsp_stall_pct;
   end

   always @(negedge clock) begin
      if (backlog_cycles != 0) begin
         rsp_blocked <= 1'b1;
         backlog_cycles <= backlog_cycles - 1;
      end else begin
         rsp_blocked <= 1'b0;
      end
   end

   // monitor: checks pixels, then records the ray accepted at this edge
   always @(posedge clock) begin
      pixel_t want;
      if (!reset) begin
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d pixels outstanding", pixels_expected.size());
            $display("FAIL voxel_ray_traversal_sponge_unit");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            pixels_seen++;
            if (pixels_expected.size() == 0) begin
               report_mismatch("unexpected pixel, outstanding", 0, 1);
            end else begin
               want = pixels_expected.pop_front();
               if (want.hit)
                  hits_seen++;
               if (rsp_tdata[7:0] !== want.red)
                  report_mismatch("red", want.red, rsp_tdata[7:0]);
               if (rsp_tdata[15:8] !== want.green)
                  report_mismatch("green", want.green, rsp_tdata[15:8]);
               if (rsp_tdata[23:16] !== want.blue)
                  report_mismatch("blue", want.blue, rsp_tdata[23:16]);
               if (rsp_tdata[24] !== want.hit)
                  report_mismatch("hit", want.hit, rsp_tdata[24]);
            end
         end
         if (req_tvalid && req_tready) begin
            pixels_expected.push_back(trace_pixel(ray_on_bus));
            rays_sent++;
         end
      end
      req_taken <= !reset && req_tvalid && req_tready;
   end

   task automatic queue_random(input int n);
      repeat (n) rays_to_send.push_back(random_ray());
   endtask

   task automatic wait_sent();
      while (rays_to_send.size() != 0 || req_tvalid)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      wait_sent();
      while (pixels_expected.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corners, ties, wraps and a guaranteed miss
      rays_to_send.push_back(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 3'b000));
      rays_to_send.push_back(make_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 32'h7FFFFFFF, 3'b000));
      rays_to_send.push_back(make_ray(16'h8000, 16'h8000, 16'h8000, 32'h80000000,
                                      32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000, 3'b111));
      rays_to_send.push_back(make_ray(16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1, '1,
                                      '1, 3'b111));
      rays_to_send.push_back(make_ray(0, 1, 1, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0,
                                      3'b000));
      rays_to_send.push_back(make_ray(16'h1234, 16'h0005, 16'h0009, 0, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 0, 0, 0, 3'b001));
      rays_to_send.push_back(make_ray(3, 7, 11, 10, 5, 5, 100, 100, 100, 3'b000));
      rays_to_send.push_back(make_ray(3, 7, 11, 10, 3, 10, 100, 100, 100, 3'b010));
      rays_to_send.push_back(make_ray(3, 7, 11, 4, 4, 9, 10, 10, 10, 3'b100));
      rays_to_send.push_back(make_ray(3, 7, 11, 4, 9, 4, 10, 10, 10, 3'b001));
      rays_to_send.push_back(make_ray(16'h7FFF, 16'h0015, 16'h0015, 0, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 1, 1, 1, 3'b000));
      rays_to_send.push_back(make_ray(16'h8000, 16'h0015, 16'h0015, 0, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 1, 1, 1, 3'b001));
      rays_to_send.push_back(make_ray(0, 16'h0015, 16'h0015, 0, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 1, 1, 1, 3'b001));
      rays_to_send.push_back(make_ray(16'h0015, 0, 16'h0015, 32'h7FFFFFFF, 0,
                                      32'h7FFFFFFF, 1, 1, 1, 3'b010));
      rays_to_send.push_back(make_ray(16'h0015, 16'h0015, 0, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 0, 1, 1, 1, 3'b100));
      rays_to_send.push_back(make_ray(16'h0021, 16'h0015, 16'h002A, 32'h7FFFFFF0,
                                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h20, 1, 1, 3'b000));
      rays_to_send.push_back(make_ray(-16'sd5, -16'sd9, -16'sd17, 7, 3, 5, 11, 13, 17,
                                      3'b111));
      rays_to_send.push_back(make_ray(16'h0105, 16'h0205, 16'h0305, 1, 1, 1, 3, 3, 3,
                                      3'b000));
      rays_to_send.push_back(make_ray(16'h4321, 16'hBCDE, 16'h5A5A, 32'h40000000,
                                      32'h3FFFFFFF, 32'h40000001, 32'h40000000,
                                      32'h40000000, 32'h40000000, 3'b101));
      rays_to_send.push_back(make_ray(16'h003F, 16'h003F, 16'h003F, 2, 1, 3, 5, 5, 5,
                                      3'b110));
      wait_drained();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      queue_random(240);
      wait_sent();

      send_idle_pct = 47;
      queue_random(240);
      // sender pauses here until every pixel is back
      wait_drained();

      send_idle_pct = 0;
      rsp_stall_pct = 47;
      queue_random(240);
      wait_sent();

      send_idle_pct = 34;
      rsp_stall_pct = 34;
      queue_random(240);
      wait_drained();

      // long output hold-off while rays keep coming, fills the pipe
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      backlog_cycles = 400;
      queue_random(120);
      wait_drained();

      repeat (LATENCY + 20) @(posedge clock);
      $display("traced %0d rays through %0d steps each, %0d pixels checked, %0d hits",
               rays_sent, STEPS, pixels_seen, hits_seen);
      $display("idle and stall mixes on both sides plus a full-pipe backpressure stretch");
      if (error_count == 0) begin
         $display("PASS voxel_ray_traversal_sponge_unit");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAIL voxel_ray_traversal_sponge_unit");
      end
      $finish;
   end

endmodule
